// File: rtl/core/rc4_stream_cipher_macros.svh
// assertion macros for the rc4 stream cipher rtl
// used by the sequencer, no other dependencies
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// plain property, checked at every rising clock edge outside reset
`define RC4_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication, checked outside reset
`define RC4_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RC4_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/rc4_pkg.sv
// shared types, codes and helpers for the rc4 stream cipher
// no dependencies
`default_nettype none

package rc4_pkg;

  localparam int unsigned ADDR_W        = 8;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned MAX_KEY_BYTES = 16;
  localparam int unsigned KEY_W         = MAX_KEY_BYTES * DATA_W;
  localparam int unsigned KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
  localparam int unsigned KEY_LEN_W     = 5;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 64;

  localparam logic CMD_CRYPT    = 1'b0;
  localparam logic CMD_SCHEDULE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

  // one read and one write request to the permutation store per cycle
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              clear;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
    logic              sched_done;
  } res_t;

  // index of the last key byte used, length clamped to 1..MAX_KEY_BYTES
  function automatic logic [KEY_IDX_W-1:0] key_last_idx(input logic [KEY_LEN_W-1:0] len);
    logic [KEY_LEN_W-1:0] n;
    n = len;
    if (n == '0) begin
      n = KEY_LEN_W'(1);
    end else if (n > KEY_LEN_W'(MAX_KEY_BYTES)) begin
      n = KEY_LEN_W'(MAX_KEY_BYTES);
    end
    n = n - KEY_LEN_W'(1);
    return n[KEY_IDX_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                 input logic [KEY_IDX_W-1:0] idx);
    return key[{idx, 3'b000} +: DATA_W];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rc4_sbox.sv
// permutation store: 256 x 8 synchronous memory, one read and one write port
// uses rc4_pkg; entries without a valid bit read back as their own index
`default_nettype none

module rc4_sbox (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rc4_pkg::mem_req_t         req_i,
  output logic [rc4_pkg::DATA_W-1:0] rd_data_o
);
  import rc4_pkg::*;

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] mem_rd_q;
  logic [DEPTH-1:0]  valid_q;
  logic              use_mem_q;
  logic [DATA_W-1:0] alt_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      mem_rd_q <= mem_q[req_i.rd_addr];
    end
  end

  // identity is restored by dropping every valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      use_mem_q <= 1'b0;
      alt_q     <= '0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        priority if (req_i.wr_en && (req_i.wr_addr == req_i.rd_addr)) begin
          // write-through for a read of the entry being written
          use_mem_q <= 1'b0;
          alt_q     <= req_i.wr_data;
        end else if (req_i.clear || !valid_q[req_i.rd_addr]) begin
          use_mem_q <= 1'b0;
          alt_q     <= req_i.rd_addr;
        end else begin
          use_mem_q <= 1'b1;
        end
      end
    end
  end

  assign rd_data_o = use_mem_q ? mem_rd_q : alt_q;

endmodule

`default_nettype wire

// File: rtl/core/rc4_ctrl.sv
// sequencer for key schedule and crypt requests: read, read, write, write
// uses rc4_pkg and the assertion macros; drives rc4_sbox
`default_nettype none
`include "rc4_stream_cipher_macros.svh"

module rc4_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [rc4_pkg::DATA_W-1:0]    data_i,
  input  logic                          last_i,
  input  logic [rc4_pkg::KEY_W-1:0]     key_i,
  input  logic [rc4_pkg::KEY_LEN_W-1:0] key_len_i,
  output rc4_pkg::mem_req_t             req_o,
  input  logic [rc4_pkg::DATA_W-1:0]    rd_data_i,
  output rc4_pkg::res_t                 res_o,
  output logic                          res_push_o,
  input  logic                          res_free_i
);
  import rc4_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD_B = 2'd1;
  localparam logic [1:0] ST_WR_A = 2'd2;
  localparam logic [1:0] ST_WR_B = 2'd3;

  logic [1:0]           state_q, state_d;
  logic                 cmd_q, cmd_d;
  logic [DATA_W-1:0]    data_q, data_d;
  logic                 last_q, last_d;
  logic [ADDR_W-1:0]    i_q, i_d;
  logic [ADDR_W-1:0]    j_q, j_d;
  logic [ADDR_W-1:0]    a_q, a_d;
  logic [ADDR_W-1:0]    b_q, b_d;
  logic [DATA_W-1:0]    va_q, va_d;
  logic [DATA_W-1:0]    vb_q, vb_d;
  logic [KEY_IDX_W-1:0] kidx_q, kidx_d;

  logic                 sched;
  logic [ADDR_W-1:0]    b_new;
  logic [ADDR_W-1:0]    t_addr;
  logic [DATA_W-1:0]    ks;
  logic [DATA_W-1:0]    kb;

  assign sched  = (cmd_q == CMD_SCHEDULE);
  assign kb     = sched ? key_byte(key_i, kidx_q) : '0;
  assign b_new  = j_q + rd_data_i + kb;
  assign t_addr = va_q + vb_q;

  // keystream entry after the swap: S[a] holds vb, S[b] holds va
  always_comb begin
    priority if (t_addr == b_q) begin
      ks = va_q;
    end else if (t_addr == a_q) begin
      ks = vb_q;
    end else begin
      ks = rd_data_i;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    data_d     = data_q;
    last_d     = last_q;
    i_d        = i_q;
    j_d        = j_q;
    a_d        = a_q;
    b_d        = b_q;
    va_d       = va_q;
    vb_d       = vb_q;
    kidx_d     = kidx_q;
    req_o      = '0;
    in_ready_o = 1'b0;
    res_push_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d       = cmd_i;
          data_d      = data_i;
          last_d      = last_i;
          req_o.rd_en = 1'b1;
          if (cmd_i == CMD_SCHEDULE) begin
            req_o.clear   = 1'b1;
            req_o.rd_addr = '0;
            a_d           = '0;
            j_d           = '0;
            kidx_d        = '0;
          end else begin
            req_o.rd_addr = i_q + ADDR_W'(1);
            a_d           = i_q + ADDR_W'(1);
            i_d           = i_q + ADDR_W'(1);
          end
          state_d = ST_RD_B;
        end
      end
      ST_RD_B: begin
        va_d          = rd_data_i;
        j_d           = b_new;
        b_d           = b_new;
        req_o.rd_en   = 1'b1;
        req_o.rd_addr = b_new;
        state_d       = ST_WR_A;
      end
      ST_WR_A: begin
        vb_d          = rd_data_i;
        req_o.wr_en   = 1'b1;
        req_o.wr_addr = a_q;
        req_o.wr_data = rd_data_i;
        req_o.rd_en   = 1'b1;
        req_o.rd_addr = va_q + rd_data_i;
        state_d       = ST_WR_B;
      end
      ST_WR_B: begin
        // this write may repeat while the result waits for the output slot
        req_o.wr_en   = 1'b1;
        req_o.wr_addr = b_q;
        req_o.wr_data = va_q;
        if (sched && (a_q != '1)) begin
          a_d           = a_q + ADDR_W'(1);
          kidx_d        = (kidx_q == key_last_idx(key_len_i)) ? '0 : kidx_q + KEY_IDX_W'(1);
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = a_q + ADDR_W'(1);
          state_d       = ST_RD_B;
        end else if (res_free_i) begin
          res_push_o = 1'b1;
          if (sched) begin
            i_d = '0;
            j_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.data       = sched ? '0 : (data_q ^ ks);
  assign res_o.last       = last_q;
  assign res_o.sched_done = sched;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= CMD_CRYPT;
      i_q     <= '0;
      j_q     <= '0;
      a_q     <= '0;
      kidx_q  <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      i_q     <= i_d;
      j_q     <= j_d;
      a_q     <= a_d;
      kidx_q  <= kidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
    b_q    <= b_d;
    va_q   <= va_d;
    vb_q   <= vb_d;
  end

  `RC4_ASSERT_IMP(a_no_idle_write, clk_i, rst_ni, state_q == ST_IDLE, !req_o.wr_en,
                  "permutation written while idle")
  `RC4_ASSERT_IMP(a_rdb_after_read, clk_i, rst_ni, state_q == ST_RD_B, $past(req_o.rd_en),
                  "second read step without a read issued before it")
  `RC4_ASSERT_NXT(a_sched_clears_idx, clk_i, rst_ni, res_push_o && sched,
                  (i_q == '0) && (j_q == '0), "indices not cleared after key schedule")
  `RC4_ASSERT_IMP(a_push_slot_free, clk_i, rst_ni, res_push_o,
                  res_free_i && (state_q == ST_WR_B), "result pushed into a full slot")

endmodule

`default_nettype wire

// File: rtl/core/rc4_stream_cipher.sv
// top level of the rc4 stream cipher: stream ports, key registers, output slot
// uses rc4_pkg, rc4_ctrl and rc4_sbox
`default_nettype none

// RC4 engine on a 256 x 8 permutation memory with one read and one write port.
// Each request gives one result. A crypt request (tuser 0) reads S[i+1] on
// acceptance, then S[j], then writes the swap back while the keystream entry
// is read. Its result is written into the output register from the last write
// state, after which the sequencer returns to idle for the next request. A key
// schedule request (tuser 1) runs 256 steps (read S[acc], write S[k], write
// S[acc] while reading the next S[k]). Its result is written into the output
// register after the last step. A new request is taken only in idle, once the
// last one has given its result; the memory reads form a chain, where each
// read address comes from the data of the read before it. A full output
// register holds the sequencer in its last write until the register drains.
// The identity permutation is restored at reset and at the start of each
// schedule at once by per-entry valid bits, so there is no clearing pass. The
// user must write key registers and key length through the cfg port only while
// no request is in flight; the block itself does not enforce this. A key length
// of 0 acts as 1 and one above 16 as 16.
module rc4_stream_cipher (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_in
  input  logic                           s_axis_tuser,  // [0] command
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [7:0] data_out
  output logic                           m_axis_tuser,  // [0] schedule_done
  output logic                           m_axis_tlast,
  input  logic                           cfg_we_i,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rc4_pkg::*;

  logic [CFG_DATA_W-1:0] key_lo_q;
  logic [CFG_DATA_W-1:0] key_hi_q;
  logic [KEY_LEN_W-1:0]  key_len_q;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rd_data;
  res_t              res;
  logic              res_push;
  logic              res_free;

  logic              out_valid_q;
  res_t              out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      key_len_q <= KEY_LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KEY_LOW:  key_lo_q  <= cfg_data_i;
        CFG_KEY_HIGH: key_hi_q  <= cfg_data_i;
        CFG_KEY_LEN:  key_len_q <= cfg_data_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (s_axis_tuser),
    .data_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .key_i      ({key_hi_q, key_lo_q}),
    .key_len_i  (key_len_q),
    .req_o      (mem_req),
    .rd_data_i  (mem_rd_data),
    .res_o      (res),
    .res_push_o (res_push),
    .res_free_i (res_free)
  );

  rc4_sbox u_sbox (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (mem_rd_data)
  );

  // output slot, refilled in the cycle it is drained
  assign res_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tuser  = out_q.sched_done;

endmodule

`default_nettype wire
